@@ rtl/gml_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gml_pkg: shared types and constants for the month layout block
// Holds the per-year record passed from front to back, the month tables
// and small arithmetic helpers used by both halves.
// ----------------------------------------------------------------------------
package gml_pkg;

	localparam int unsigned YEAR_W   = 14;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned DAYS_W   = 5;
	localparam int unsigned COL_W    = 3;
	localparam int unsigned WEEK_W   = 6;
	localparam int unsigned SUM_W    = 15;
	localparam int unsigned PROD_W   = 27;

	// floor(x / 100) for x < 2**14 equals (x * 5243) >> 19.
	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam int unsigned RECIP_SHIFT = 19;

	localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd0;
	localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd11;

	localparam logic [DAYS_W-1:0] FEB_LEAP   = 5'd29;
	localparam logic [DAYS_W-1:0] FEB_COMMON = 5'd28;

	// Column of January 1 above this value starts the year in week row 0.
	localparam logic [COL_W-1:0] THURSDAY_COL = 3'd3;
	localparam logic [COL_W-1:0] SUNDAY_COL   = 3'd6;

	// Month lengths; the unused codes twelve to fifteen read as 31.
	localparam logic [DAYS_W-1:0] BASE_DAYS [16] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31,
		5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31
	};

	typedef struct packed {
		logic [COL_W-1:0] jan_col;
		logic             leap;
	} year_info_t;

	function automatic logic [DAYS_W-1:0] month_days(
		input logic [MONTH_W-1:0] month,
		input logic               leap
	);
		logic [DAYS_W-1:0] d;
		if (month == MONTH_FEB) begin
			d = leap ? FEB_LEAP : FEB_COMMON;
		end else begin
			d = BASE_DAYS[month];
		end
		return d;
	endfunction

	// Residue modulo 7 using 8 = 1 (mod 7): sum the octal digits twice,
	// then one conditional subtract.
	function automatic logic [COL_W-1:0] mod7(input logic [SUM_W-1:0] x);
		logic [5:0] s;
		logic [3:0] t;
		s = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]);
		t = 4'(s[2:0]) + 4'(s[5:3]);
		if (t >= 4'd7) begin
			t = t - 4'd7;
		end
		return t[COL_W-1:0];
	endfunction

endpackage

@@ rtl/gml_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gml_front: year classifier
// Three-stage pipeline that finds the leap flag and the Monday-based column
// of January 1 for each accepted year.
// ----------------------------------------------------------------------------
module gml_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic [13:0]              year,
	output logic                     full,
	output logic                     info_valid,
	input  logic                     info_ready,
	output gml_pkg::year_info_t      info
);
	import gml_pkg::*;

	logic                  v_s1, v_s2, v_s3;
	logic [YEAR_W-1:0]     year_s1, prev_s1;
	logic [PROD_W-1:0]     prod_s1;
	logic [SUM_W-1:0]      sum_s2;
	logic                  leap_s2;
	year_info_t            info_s3;

	logic                  adv1, adv2, adv3;
	logic [YEAR_W-1:0]     prev;
	logic [7:0]            qp;
	logic [YEAR_W-1:0]     rp;
	logic                  leap;
	logic [SUM_W-1:0]      sum;
	logic [COL_W-1:0]      code;

	assign adv3 = !v_s3 || info_ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign full = !adv1;

	assign prev = (year == '0) ? '0 : year - 14'd1;

	// Quotient and remainder of (year - 1) by 100.
	assign qp = prod_s1[PROD_W-1:RECIP_SHIFT];
	assign rp = prev_s1 - (14'(qp) * 14'd100);
	// A multiple of 100 has prev % 100 == 99; it is a leap year only when the
	// century count (qp + 1) is a multiple of 4.
	assign leap = (year_s1[1:0] == 2'b00) && ((rp != 14'd99) || (qp[1:0] == 2'b11));
	assign sum  = SUM_W'(year_s1) + SUM_W'(prev_s1[YEAR_W-1:2]) - SUM_W'(qp)
		+ SUM_W'(qp[7:2]);

	assign code = mod7(sum_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= push;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && push) begin
			year_s1 <= year;
			prev_s1 <= prev;
			prod_s1 <= PROD_W'(prev) * PROD_W'(RECIP_100);
		end
		if (adv2 && v_s1) begin
			sum_s2  <= sum;
			leap_s2 <= leap;
		end
		if (adv3 && v_s2) begin
			// Code 0 is Sunday; shift to a Monday-first column.
			info_s3.jan_col <= (code == 3'd0) ? SUNDAY_COL : code - 3'd1;
			info_s3.leap    <= leap_s2;
		end
	end

	assign info_valid = v_s3;
	assign info       = info_s3;

endmodule

@@ rtl/gml_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gml_queue: year record queue
// Small first-in first-out buffer between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module gml_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	output logic                wr_ready,
	input  gml_pkg::year_info_t wr_data,
	output logic                rd_valid,
	input  logic                rd_ready,
	output gml_pkg::year_info_t rd_data
);
	import gml_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	year_info_t         mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr, do_rd;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ rtl/gml_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gml_back: month sequencer
// Walks the twelve months of one year record and fills the result register,
// carrying the weekday column and the week row from month to month.
// ----------------------------------------------------------------------------
module gml_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                info_valid,
	output logic                info_ready,
	input  gml_pkg::year_info_t info,
	input  logic                pop,
	output logic                empty,
	output logic [3:0]          month_index,
	output logic [4:0]          days_in_month,
	output logic [2:0]          first_column,
	output logic [5:0]          first_week,
	output logic                last_month
);
	import gml_pkg::*;

	logic                  active_q;
	logic [MONTH_W-1:0]    month_q;
	logic [COL_W-1:0]      col_q;
	logic [WEEK_W-1:0]     week_q;
	logic                  leap_q;

	logic                  out_v_q;
	logic [MONTH_W-1:0]    out_month_q;
	logic [DAYS_W-1:0]     out_days_q;
	logic [COL_W-1:0]      out_col_q;
	logic [WEEK_W-1:0]     out_week_q;
	logic                  out_last_q;

	logic                  gen, load, is_last;
	logic [DAYS_W-1:0]     days;
	logic [3:0]            col_sum;
	logic [COL_W-1:0]      next_col;
	logic [WEEK_W-1:0]     next_week;

	assign is_last = (month_q == MONTH_LAST);
	assign gen     = active_q && (!out_v_q || pop);
	assign load    = info_valid && (!active_q || (gen && is_last));
	assign info_ready = load;

	assign days = month_days(month_q, leap_q);

	// days mod 7 is days - 28 for every month length.
	assign col_sum  = 4'(col_q) + 4'(days - 5'd28);
	assign next_col = (col_sum >= 4'd7) ? 3'(col_sum - 4'd7) : col_sum[COL_W-1:0];
	// (days + column) / 7 is 5 when the sum reaches 35, else 4.
	assign next_week = week_q + (((6'(days) + 6'(col_q)) >= 6'd35) ? 6'd5 : 6'd4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (load) begin
				active_q <= 1'b1;
			end else if (gen && is_last) begin
				active_q <= 1'b0;
			end
			if (gen) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			month_q <= MONTH_JAN;
			col_q   <= info.jan_col;
			week_q  <= (info.jan_col > THURSDAY_COL) ? 6'd0 : 6'd1;
			leap_q  <= info.leap;
		end else if (gen) begin
			month_q <= month_q + 4'd1;
			col_q   <= next_col;
			week_q  <= next_week;
		end
		if (gen) begin
			out_month_q <= month_q;
			out_days_q  <= days;
			out_col_q   <= col_q;
			out_week_q  <= week_q;
			out_last_q  <= is_last;
		end
	end

	assign empty         = !out_v_q;
	assign month_index   = out_month_q;
	assign days_in_month = out_days_q;
	assign first_column  = out_col_q;
	assign first_week    = out_week_q;
	assign last_month    = out_last_q;

endmodule

@@ rtl/gregorian_month_layout.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_month_layout: Monday-first month grid layout for one year
// Takes a Gregorian year and returns twelve month records, January first.
// ----------------------------------------------------------------------------
// Each year pushed in produces twelve results, one per month, each giving the
// month number, its day count (February is 29 in leap years), the column of
// day 1 with Monday as column 0, and the week row that holds day 1; the
// December result carries last_month. A year transfer is taken whenever full
// is low. The month sequencer produces one month result per cycle while pop
// keeps up. When the block is idle, a year takes this path to the ports: the
// transfer itself fills the first of three pipeline stages in the classifier
// (a reciprocal multiply for the division by 100, the weekday sum, the
// residue modulo 7), then come the record queue, the sequencer load, and
// the result register. The classifier keeps taking years while the sequencer
// works, until the queue and its pipeline fill. Year zero is treated as a
// leap year whose January 1 is a Sunday, and years above 9999 follow the
// same arithmetic.
// ----------------------------------------------------------------------------
module gregorian_month_layout #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [13:0] year,
	output logic        empty,
	input  logic        pop,
	output logic [3:0]  month_index,
	output logic [4:0]  days_in_month,
	output logic [2:0]  first_column,
	output logic [5:0]  first_week,
	output logic        last_month
);
	import gml_pkg::*;

	// Classifier to queue.
	logic        f_valid, f_ready;
	year_info_t  f_info;
	// Queue to sequencer.
	logic        b_valid, b_ready;
	year_info_t  b_info;

	// The classifier stalls only on its own output, so full covers the case
	// where the queue holds a record for each year still being sequenced.
	gml_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.year       (year),
		.full       (full),
		.info_valid (f_valid),
		.info_ready (f_ready),
		.info       (f_info)
	);

	gml_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  (f_info),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_data  (b_info)
	);

	// The sequencer loads the next record in the same cycle that it issues
	// December, so consecutive years follow without a gap.
	gml_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.info_valid    (b_valid),
		.info_ready    (b_ready),
		.info          (b_info),
		.pop           (pop),
		.empty         (empty),
		.month_index   (month_index),
		.days_in_month (days_in_month),
		.first_column  (first_column),
		.first_week    (first_week),
		.last_month    (last_month)
	);

	// The end-of-year flag must sit on December and nowhere else.
	a_last_is_december: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (last_month == (month_index == MONTH_LAST)))
		else $error("last_month does not match December");

	// Within a year, the result after a transfer is the next month.
	a_month_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last_month) |=>
			(empty || (month_index == $past(month_index) + 4'd1)))
		else $error("month sequence skipped or repeated");

	// A new year always starts with January.
	a_year_starts_january: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && last_month) |=> (empty || (month_index == MONTH_JAN)))
		else $error("year did not restart at January");

	// Day counts come only from the month table and the February rule; columns stop at Sunday.
	a_days_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (days_in_month >= 5'd28 && days_in_month <= 5'd31
			&& first_column <= SUNDAY_COL))
		else $error("day count or column out of range");

endmodule
